// ----- hdl/lcsp_pkg.sv -----
package lcsp_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_SENSOR_COUNT = 3;
    localparam int DEF_MAX_LEN      = 64;
    localparam int DEF_VALUE_BITS   = 16;

    localparam int LIMIT_BITS = 16;
    localparam int NAME_LEN   = 6;

    // ASCII codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [3:0] NAME_FAIL   = 4'd15;
    localparam logic [3:0] FIELD_LIMIT = 4'd15;

    typedef enum logic [2:0] {
        ST_APPLIED   = 3'd0,
        ST_OTHER     = 3'd1,
        ST_CKSUM     = 3'd2,
        ST_MALFORMED = 3'd3,
        ST_OVERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        logic neg;
        logic started;
        logic stopped;
    } field_flags_t;

    // Command name CONLIM, one character per position
    function automatic logic [7:0] cmd_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h4F;
            4'd2:    c = 8'h4E;
            4'd3:    c = 8'h4C;
            4'd4:    c = 8'h49;
            4'd5:    c = 8'h4D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Power-up limits, upper then lower per sensor
    function automatic logic [LIMIT_BITS-1:0] limit_init(input int slot);
        logic [LIMIT_BITS-1:0] v;
        case (slot)
            0:       v = 16'd35;
            1:       v = 16'd15;
            2:       v = 16'd65;
            3:       v = 16'd35;
            4:       v = 16'd1400;
            5:       v = 16'd650;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- hdl/limit_command_sentence_parser.sv -----
// A carriage return passes from the byte register through one pass of parse logic into the
//   result register, which presents its status transaction.
// Throughput: one byte per cycle. in_stall rises only while a carriage return waits in
//   the byte register behind a result that the output side is stalling.
// Reset (rst_n, async, active low): idle outside any sentence, parse state cleared,
//   limit table reloaded with its power-up values.
module limit_command_sentence_parser #(
    parameter int SENSOR_COUNT = lcsp_pkg::DEF_SENSOR_COUNT,
    parameter int MAX_LEN      = lcsp_pkg::DEF_MAX_LEN,
    parameter int VALUE_BITS   = lcsp_pkg::DEF_VALUE_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [1:0]                      sensor_index,
    output logic                            upper_selected,
    output logic [lcsp_pkg::LIMIT_BITS-1:0] new_limit
);
    import lcsp_pkg::*;

    localparam int CNT_BITS  = $clog2(MAX_LEN);
    localparam int SLOTS     = 2 * SENSOR_COUNT;
    localparam int SLOT_BITS = $clog2(SLOTS);

    // Byte register (input side)
    logic                  hold_valid_reg;
    logic [7:0]            hold_byte_reg;

    // Sentence state
    logic                  in_sentence_reg, in_sentence_next;
    logic [CNT_BITS-1:0]   byte_count_reg, byte_count_next;
    logic                  overflowed_reg, overflowed_next;
    logic [3:0]            field_number_reg, field_number_next;
    logic [7:0]            running_xor_reg, running_xor_next;
    logic [7:0]            xor_before_comma_reg, xor_before_comma_next;
    logic [VALUE_BITS-1:0] field_accum_reg, field_accum_next;
    field_flags_t          field_flags_reg, field_flags_next;
    logic [3:0]            name_match_reg, name_match_next;
    logic [VALUE_BITS-1:0] saved_reg [3];
    logic [VALUE_BITS-1:0] saved_next [3];
    logic [LIMIT_BITS-1:0] limit_table_reg [SLOTS];

    // Result register (output side)
    logic                  out_valid_reg;
    logic [2:0]            status_reg, status_next;
    logic [1:0]            index_reg, index_next;
    logic                  upper_reg, upper_next;
    logic [LIMIT_BITS-1:0] limit_reg, limit_next;

    // Field decoder outputs
    logic [VALUE_BITS-1:0] dec_accum;
    field_flags_t          dec_flags;
    logic [VALUE_BITS-1:0] field_val;

    logic                  ch_dollar;
    logic                  sentence_end;
    logic                  out_free;
    logic                  advance;
    logic                  table_write;
    logic [SLOT_BITS-1:0]  table_slot;

    lcsp_field_dec #(
        .VALUE_BITS (VALUE_BITS)
    ) u_field_dec (
        .accum      (field_accum_reg),
        .flags      (field_flags_reg),
        .ch         (hold_byte_reg),
        .accum_next (dec_accum),
        .flags_next (dec_flags),
        .value      (field_val)
    );

    // A byte that ends a sentence needs room in the result register; any other byte
    // moves through regardless of the output side.
    assign ch_dollar    = (hold_byte_reg == CH_DOLLAR);
    assign sentence_end = in_sentence_reg && (hold_byte_reg == CH_CR);
    assign out_free     = !out_valid_reg || !out_stall;
    assign advance      = hold_valid_reg && (out_free || !sentence_end);
    assign in_stall     = hold_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            hold_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            hold_byte_reg <= rx_byte;
        end
    end

    // Per-byte parse step
    always_comb
    begin
        in_sentence_next      = in_sentence_reg;
        byte_count_next       = byte_count_reg;
        overflowed_next       = overflowed_reg;
        field_number_next     = field_number_reg;
        running_xor_next      = running_xor_reg;
        xor_before_comma_next = xor_before_comma_reg;
        field_accum_next      = field_accum_reg;
        field_flags_next      = field_flags_reg;
        name_match_next       = name_match_reg;
        saved_next            = saved_reg;

        if (ch_dollar)
        begin
            // '$' always (re)starts a sentence
            in_sentence_next      = 1'b1;
            byte_count_next       = CNT_BITS'(1);
            overflowed_next       = 1'b0;
            field_number_next     = 4'd0;
            running_xor_next      = CH_DOLLAR;
            xor_before_comma_next = 8'd0;
            name_match_next       = 4'd0;
            field_accum_next      = '0;
            field_flags_next      = '0;
            for (int i = 0; i < 3; i++)
            begin
                saved_next[i] = '0;
            end
        end
        else if (sentence_end)
        begin
            in_sentence_next = 1'b0;
        end
        else if (in_sentence_reg && !overflowed_reg)
        begin
            if (byte_count_reg >= CNT_BITS'(MAX_LEN - 1))
            begin
                overflowed_next = 1'b1;
            end
            else
            begin
                byte_count_next = byte_count_reg + CNT_BITS'(1);
                if (hold_byte_reg == CH_COMMA)
                begin
                    if ((field_number_reg >= 4'd3) && (field_number_reg <= 4'd5))
                    begin
                        saved_next[2'(field_number_reg - 4'd3)] = field_val;
                    end
                    if (field_number_reg < FIELD_LIMIT)
                    begin
                        field_number_next = field_number_reg + 4'd1;
                    end
                    xor_before_comma_next = running_xor_reg;
                    running_xor_next      = running_xor_reg ^ hold_byte_reg;
                    field_accum_next      = '0;
                    field_flags_next      = '0;
                end
                else
                begin
                    running_xor_next = running_xor_reg ^ hold_byte_reg;
                    if (field_number_reg == 4'd0)
                    begin
                        if ((name_match_reg < 4'(NAME_LEN)) &&
                            (hold_byte_reg == cmd_char(name_match_reg)))
                        begin
                            name_match_next = name_match_reg + 4'd1;
                        end
                        else
                        begin
                            name_match_next = NAME_FAIL;
                        end
                    end
                    field_accum_next = dec_accum;
                    field_flags_next = dec_flags;
                end
            end
        end
    end

    // End-of-sentence verdict, in priority order
    always_comb
    begin
        index_next  = 2'd0;
        upper_next  = 1'b0;
        limit_next  = '0;
        table_write = 1'b0;
        if (overflowed_reg)
        begin
            status_next = ST_OVERFLOW;
        end
        else if (field_number_reg == 4'd0)
        begin
            status_next = ST_MALFORMED;
        end
        else if (field_val[7:0] != xor_before_comma_reg)
        begin
            status_next = ST_CKSUM;
        end
        else if (name_match_reg != 4'(NAME_LEN))
        begin
            status_next = ST_OTHER;
        end
        else if ((field_number_reg < 4'd6) ||
                 (saved_reg[0] >= VALUE_BITS'(SENSOR_COUNT)))
        begin
            status_next = ST_MALFORMED;
        end
        else
        begin
            status_next = ST_APPLIED;
            index_next  = 2'(saved_reg[0]);
            upper_next  = |saved_reg[1];
            limit_next  = LIMIT_BITS'(saved_reg[2]);
            table_write = 1'b1;
        end
    end

    // Upper limit sits at the even slot, lower at the odd one
    assign table_slot = SLOT_BITS'({saved_reg[0], !upper_next});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_sentence_reg      <= 1'b0;
            byte_count_reg       <= '0;
            overflowed_reg       <= 1'b0;
            field_number_reg     <= 4'd0;
            running_xor_reg      <= 8'd0;
            xor_before_comma_reg <= 8'd0;
            field_accum_reg      <= '0;
            field_flags_reg      <= '0;
            name_match_reg       <= 4'd0;
            for (int i = 0; i < 3; i++)
            begin
                saved_reg[i] <= '0;
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                limit_table_reg[i] <= limit_init(i);
            end
        end
        else if (advance)
        begin
            in_sentence_reg      <= in_sentence_next;
            byte_count_reg       <= byte_count_next;
            overflowed_reg       <= overflowed_next;
            field_number_reg     <= field_number_next;
            running_xor_reg      <= running_xor_next;
            xor_before_comma_reg <= xor_before_comma_next;
            field_accum_reg      <= field_accum_next;
            field_flags_reg      <= field_flags_next;
            name_match_reg       <= name_match_next;
            saved_reg            <= saved_next;
            if (sentence_end && table_write)
            begin
                limit_table_reg[table_slot] <= limit_next;
            end
        end
    end

    // Result register: loads when a sentence ends, clears once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && sentence_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sentence_end)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            upper_reg  <= upper_next;
            limit_reg  <= limit_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign sensor_index   = index_reg;
    assign upper_selected = upper_reg;
    assign new_limit      = limit_reg;

endmodule

// ----- hdl/lcsp_field_dec.sv -----
module lcsp_field_dec #(
    parameter int VALUE_BITS = lcsp_pkg::DEF_VALUE_BITS
) (
    input  logic [VALUE_BITS-1:0]  accum,
    input  lcsp_pkg::field_flags_t flags,
    input  logic [7:0]             ch,
    output logic [VALUE_BITS-1:0]  accum_next,
    output lcsp_pkg::field_flags_t flags_next,
    output logic [VALUE_BITS-1:0]  value
);
    import lcsp_pkg::*;

    logic is_digit;
    logic is_space;
    logic is_sign;
    logic [VALUE_BITS-1:0] digit_val;

    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_space  = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_FF));
    assign is_sign   = (ch == CH_PLUS) || (ch == CH_MINUS);
    assign digit_val = {{(VALUE_BITS-4){1'b0}}, ch[3:0]};

    // atoi-style step: skip leading blanks, one sign, then digits until a non-digit
    always_comb
    begin
        accum_next = accum;
        flags_next = flags;
        if (!flags.stopped && !(!flags.started && is_space))
        begin
            if (!flags.started && is_sign)
            begin
                flags_next.started = 1'b1;
                flags_next.neg     = (ch == CH_MINUS);
            end
            else if (is_digit)
            begin
                flags_next.started = 1'b1;
                accum_next = (accum << 3) + (accum << 1) + digit_val;
            end
            else
            begin
                flags_next.stopped = 1'b1;
            end
        end
    end

    assign value = flags.neg ? ({VALUE_BITS{1'b0}} - accum) : accum;

endmodule

// ----- hdl/lcsp_checker.sv -----
module lcsp_checker #(
    parameter int SENSOR_COUNT = lcsp_pkg::DEF_SENSOR_COUNT
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input logic [2:0]                      status,
    input logic [1:0]                      sensor_index,
    input logic                            upper_selected,
    input logic [lcsp_pkg::LIMIT_BITS-1:0] new_limit
);
    import lcsp_pkg::*;

    // Input side only backs up behind a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a blocked result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= ST_OVERFLOW))
        else $error("undefined status code");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_APPLIED)) |->
            ((sensor_index == 2'd0) && !upper_selected && (new_limit == '0)))
        else $error("payload set on a non-applied result");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_APPLIED)) |-> (int'(sensor_index) < SENSOR_COUNT))
        else $error("applied sensor index out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(status) && $stable(sensor_index) &&
             $stable(upper_selected) && $stable(new_limit)))
        else $error("stalled result changed");

endmodule

bind limit_command_sentence_parser lcsp_checker #(
    .SENSOR_COUNT (SENSOR_COUNT)
) u_lcsp_checker (.*);
